FILE: rtl/okvt_pkg.sv
// Shared definitions for the ordered key/value table.
// Holds opcodes, parameter defaults and the controller/datapath structs; no dependencies.
`timescale 1ns / 1ps

package okvt_pkg;

  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_UPDATE    = 3'd1;
  localparam logic [2:0] OP_UPSERT    = 3'd2;
  localparam logic [2:0] OP_ERASE     = 3'd3;
  localparam logic [2:0] OP_GET_KEY   = 3'd4;
  localparam logic [2:0] OP_CONTAINS  = 3'd5;
  localparam logic [2:0] OP_GET_POS   = 3'd6;

  typedef struct packed {
    logic load_req;
    logic idx_clr;
    logic idx_pos;
    logic idx_inc;
    logic rd_en;
    logic rd_next;
    logic wr_en;
    logic wr_shift;
    logic wr_at_count;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
    logic ok;
    logic full;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       key_match;
    logic       idx_last;
    logic       cnt_zero;
    logic       cnt_full;
    logic       pos_ok;
    logic       out_busy;
  } sts_t;

endpackage

FILE: rtl/ordered_key_value_table.sv
// Ordered key/value table: insertion-ordered map of unique keys over one entry memory.
// Key ops scan the entries in order for a match (up to ENTRIES) and then resolve; an erase
// then shifts every later entry down by one. Get by position reads that entry directly.
// Requests are taken one at a time, only while idle. The next beat may be taken while a reply
// waits in the output register; its own reply is held back until that register is free.
// Reset: count and handshake state clear at once; memory contents undefined, no clearing pass.
`timescale 1ns / 1ps

module ordered_key_value_table #(
  parameter int ENTRIES     = okvt_pkg::DEF_ENTRIES,
  parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH,
  localparam int IDX_W      = $clog2(ENTRIES),
  localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             opcode_i,
  input  logic [KEY_WIDTH-1:0]   req_key_i,
  input  logic [VALUE_WIDTH-1:0] req_value_i,
  input  logic [IDX_W-1:0]       position_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   ok_o,
  output logic [KEY_WIDTH-1:0]   found_key_o,
  output logic [VALUE_WIDTH-1:0] found_value_o,
  output logic [CNT_W-1:0]       count_o,
  output logic                   full_res_o
);

  okvt_pkg::cmd_t cmd;
  okvt_pkg::sts_t sts;

  okvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  okvt_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .req_key_i     (req_key_i),
    .req_value_i   (req_value_i),
    .position_i    (position_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .ok_o          (ok_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o),
    .count_o       (count_o),
    .full_res_o    (full_res_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(ENTRIES)))
    else $error("reply count exceeds table size");

  a_full_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_res_o) |-> (!ok_o && (count_o == CNT_W'(ENTRIES))))
    else $error("full reply without a full table or with ok set");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> ((found_key_o == '0) && (found_value_o == '0)))
    else $error("failed reply carries entry data");

endmodule

FILE: rtl/okvt_ctrl.sv
// Sequencer for the ordered key/value table: scan, resolve, shift and reply.
// Depends on okvt_pkg for opcodes and the command/status structs.
`timescale 1ns / 1ps

module okvt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  okvt_pkg::sts_t sts_i,
  output okvt_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_RESOLVE,
    S_SH_RD,
    S_SH_WR,
    S_PRD,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   ok_q, ok_d;
  logic   full_q, full_d;
  logic   found_q, found_d;
  logic   hit_q, hit_d;

  always_comb begin
    state_d    = state_q;
    ok_d       = ok_q;
    full_d     = full_q;
    found_d    = found_q;
    hit_d      = hit_q;
    cmd_o      = '0;
    cmd_o.ok    = ok_q;
    cmd_o.full  = full_q;
    cmd_o.found = found_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_START;
        end
      end
      S_START: begin
        ok_d    = 1'b0;
        full_d  = 1'b0;
        found_d = 1'b0;
        hit_d   = 1'b0;
        case (sts_i.opcode)
          okvt_pkg::OP_GET_POS: begin
            if (sts_i.pos_ok) begin
              cmd_o.idx_pos = 1'b1;
              state_d       = S_PRD;
            end else begin
              state_d = S_DONE;
            end
          end
          okvt_pkg::OP_INSERT, okvt_pkg::OP_UPDATE, okvt_pkg::OP_UPSERT,
          okvt_pkg::OP_ERASE, okvt_pkg::OP_GET_KEY, okvt_pkg::OP_CONTAINS: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = sts_i.cnt_zero ? S_RESOLVE : S_RD;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (sts_i.key_match) begin
          hit_d   = 1'b1;
          state_d = S_RESOLVE;
        end else if (sts_i.idx_last) begin
          state_d = S_RESOLVE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_RESOLVE: begin
        state_d = S_DONE;
        case (sts_i.opcode)
          okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT: begin
            if (hit_q) begin
              if (sts_i.opcode == okvt_pkg::OP_UPSERT) begin
                cmd_o.wr_en = 1'b1;
                ok_d        = 1'b1;
              end
            end else if (sts_i.cnt_full) begin
              full_d = 1'b1;
            end else begin
              cmd_o.wr_en       = 1'b1;
              cmd_o.wr_at_count = 1'b1;
              cmd_o.cnt_inc     = 1'b1;
              ok_d              = 1'b1;
            end
          end
          okvt_pkg::OP_UPDATE: begin
            if (hit_q) begin
              cmd_o.wr_en = 1'b1;
              ok_d        = 1'b1;
            end
          end
          okvt_pkg::OP_ERASE: begin
            if (hit_q) begin
              ok_d    = 1'b1;
              state_d = S_SH_RD;
            end
          end
          okvt_pkg::OP_GET_KEY: begin
            ok_d    = hit_q;
            found_d = hit_q;
          end
          okvt_pkg::OP_CONTAINS: begin
            ok_d = hit_q;
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
      end
      S_SH_RD: begin
        if (sts_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SH_RD;
      end
      S_PRD: begin
        cmd_o.rd_en = 1'b1;
        ok_d        = 1'b1;
        found_d     = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ok_q    <= 1'b0;
      full_q  <= 1'b0;
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      full_q  <= full_d;
      found_q <= found_d;
      hit_q   <= hit_d;
    end
  end

endmodule

FILE: rtl/okvt_dp.sv
// Datapath for the ordered key/value table: request latch, entry memory,
// scan index, entry count and result register. Depends on okvt_pkg.
`timescale 1ns / 1ps

module okvt_dp #(
  parameter int ENTRIES     = okvt_pkg::DEF_ENTRIES,
  parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH,
  localparam int IDX_W      = $clog2(ENTRIES),
  localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  okvt_pkg::cmd_t         cmd_i,
  output okvt_pkg::sts_t         sts_o,
  input  logic [2:0]             opcode_i,
  input  logic [KEY_WIDTH-1:0]   req_key_i,
  input  logic [VALUE_WIDTH-1:0] req_value_i,
  input  logic [IDX_W-1:0]       position_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   ok_o,
  output logic [KEY_WIDTH-1:0]   found_key_o,
  output logic [VALUE_WIDTH-1:0] found_value_o,
  output logic [CNT_W-1:0]       count_o,
  output logic                   full_res_o
);

  localparam int ENT_W = KEY_WIDTH + VALUE_WIDTH;

  logic [2:0]             op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]       pos_q;
  logic [IDX_W-1:0]       idx_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [ENT_W-1:0]       mem_q [ENTRIES];
  logic [ENT_W-1:0]       rd_q;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENT_W-1:0]       wr_data;
  logic                   out_valid_q;
  logic                   ok_q;
  logic                   full_q;
  logic [KEY_WIDTH-1:0]   fkey_q;
  logic [VALUE_WIDTH-1:0] fval_q;
  logic [CNT_W-1:0]       ocnt_q;

  assign rd_addr = cmd_i.rd_next ? idx_q + IDX_W'(1) : idx_q;
  assign wr_addr = cmd_i.wr_at_count ? cnt_q[IDX_W-1:0] : idx_q;
  assign wr_data = cmd_i.wr_shift ? rd_q : {key_q, val_q};

  assign sts_o.opcode    = op_q;
  assign sts_o.key_match = (rd_q[ENT_W-1:VALUE_WIDTH] == key_q);
  assign sts_o.idx_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.cnt_full  = (cnt_q == CNT_W'(ENTRIES));
  assign sts_o.pos_ok    = (CNT_W'(pos_q) < cnt_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= opcode_i;
      key_q <= req_key_i;
      val_q <= req_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.idx_pos) begin
      idx_q <= pos_q;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.out_load) begin
      ok_q   <= cmd_i.ok;
      full_q <= cmd_i.full;
      fkey_q <= cmd_i.found ? rd_q[ENT_W-1:VALUE_WIDTH] : '0;
      fval_q <= cmd_i.found ? rd_q[VALUE_WIDTH-1:0] : '0;
      ocnt_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign full_res_o    = full_q;
  assign found_key_o   = fkey_q;
  assign found_value_o = fval_q;
  assign count_o       = ocnt_q;

endmodule

FILE: dv/okvt_reply_checker.sv
// Reply checker for the ordered key/value table: watches both channels, keeps a shadow
// table, predicts each reply and compares it field by field. Depends on okvt_pkg.
`timescale 1ns / 1ps

module okvt_reply_checker #(
  parameter int ENTRIES     = okvt_pkg::DEF_ENTRIES,
  parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH,
  localparam int IDX_W      = $clog2(ENTRIES),
  localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [2:0]             opcode_i,
  input  logic [KEY_WIDTH-1:0]   req_key_i,
  input  logic [VALUE_WIDTH-1:0] req_value_i,
  input  logic [IDX_W-1:0]       position_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   ok_i,
  input  logic [KEY_WIDTH-1:0]   found_key_i,
  input  logic [VALUE_WIDTH-1:0] found_value_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic                   full_res_i,
  output int unsigned            errors_o,
  output int unsigned            pending_o
);

  typedef struct packed {
    logic                   ok;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]       count;
    logic                   full;
  } table_reply_t;

  logic [KEY_WIDTH-1:0]   shadow_keys   [ENTRIES];
  logic [VALUE_WIDTH-1:0] shadow_values [ENTRIES];
  int                     shadow_count;
  table_reply_t           replies_due[$];

  function automatic table_reply_t table_apply(logic [2:0] op, logic [KEY_WIDTH-1:0] key,
                                               logic [VALUE_WIDTH-1:0] value,
                                               logic [IDX_W-1:0] pos);
    table_reply_t r;
    int hit;
    r = '0;
    hit = -1;
    for (int i = shadow_count - 1; i >= 0; i--)
      if (shadow_keys[i] == key) hit = i;
    case (op)
      okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT: begin
        if (hit >= 0) begin
          if (op == okvt_pkg::OP_UPSERT) begin
            shadow_values[hit] = value;
            r.ok = 1'b1;
          end
        end else if (shadow_count >= ENTRIES) begin
          r.full = 1'b1;
        end else begin
          shadow_keys[shadow_count]   = key;
          shadow_values[shadow_count] = value;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      okvt_pkg::OP_UPDATE: begin
        if (hit >= 0) begin
          shadow_values[hit] = value;
          r.ok = 1'b1;
        end
      end
      okvt_pkg::OP_ERASE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
          end
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      okvt_pkg::OP_GET_KEY: begin
        if (hit >= 0) begin
          r.ok    = 1'b1;
          r.key   = shadow_keys[hit];
          r.value = shadow_values[hit];
        end
      end
      okvt_pkg::OP_CONTAINS: begin
        if (hit >= 0) r.ok = 1'b1;
      end
      okvt_pkg::OP_GET_POS: begin
        if (int'(pos) < shadow_count) begin
          r.ok    = 1'b1;
          r.key   = shadow_keys[pos];
          r.value = shadow_values[pos];
        end
      end
      default: ;
    endcase
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      replies_due.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        replies_due.push_back(table_apply(opcode_i, req_key_i, req_value_i, position_i));
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply beat, ok %0b key %0h value %0h count %0d",
                   $time, ok_i, found_key_i, found_value_i, count_i);
          errors_o++;
        end else begin
          want = replies_due.pop_front();
          compare_field("ok", 64'(want.ok), 64'(ok_i));
          compare_field("found_key", 64'(want.key), 64'(found_key_i));
          compare_field("found_value", 64'(want.value), 64'(found_value_i));
          compare_field("count", 64'(want.count), 64'(count_i));
          compare_field("full_res", 64'(want.full), 64'(full_res_i));
        end
      end
      pending_o = replies_due.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Top of the ordered key/value table testbench: clock, reset, request and reply stimulus,
// watchdog and verdict. Depends on okvt_pkg, ordered_key_value_table and okvt_reply_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES     = okvt_pkg::DEF_ENTRIES;
  localparam int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH;
  localparam int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam logic [2:0] OP_NONE = 3'd7;
  localparam int KEY_POOL      = 20;
  localparam int PHASE_ITEMS   = 282;
  localparam int DRAIN_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [2:0]             opcode_i    = OP_NONE;
  logic [KEY_WIDTH-1:0]   req_key_i   = '0;
  logic [VALUE_WIDTH-1:0] req_value_i = '0;
  logic [IDX_W-1:0]       position_i  = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   ok_o;
  logic [KEY_WIDTH-1:0]   found_key_o;
  logic [VALUE_WIDTH-1:0] found_value_o;
  logic [CNT_W-1:0]       count_o;
  logic                   full_res_o;

  int unsigned mismatches;
  int unsigned replies_pending;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;
  logic [KEY_WIDTH-1:0] key_pool[KEY_POOL];

  ordered_key_value_table uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .req_key_i, .req_value_i,
    .position_i, .out_valid_o, .out_ready_i, .ok_o, .found_key_o, .found_value_o,
    .count_o, .full_res_o
  );

  okvt_reply_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .req_key_i,
    .req_value_i, .position_i, .out_valid_i(out_valid_o), .out_ready_i, .ok_i(ok_o),
    .found_key_i(found_key_o), .found_value_i(found_value_o), .count_i(count_o),
    .full_res_i(full_res_o), .errors_o(mismatches), .pending_o(replies_pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(logic [2:0] op, logic [KEY_WIDTH-1:0] key,
                              logic [VALUE_WIDTH-1:0] value, logic [IDX_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    req_key_i   <= key;
    req_value_i <= value;
    position_i  <= pos;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(KEY_POOL - 1)];
  endfunction

  // Grow mode favours inserts so the table fills; shrink mode favours erases.
  function automatic logic [2:0] pick_opcode(bit growing);
    int r;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 35) return okvt_pkg::OP_INSERT;
      if (r < 45) return okvt_pkg::OP_UPDATE;
      if (r < 60) return okvt_pkg::OP_UPSERT;
      if (r < 65) return okvt_pkg::OP_ERASE;
      if (r < 75) return okvt_pkg::OP_GET_KEY;
      if (r < 83) return okvt_pkg::OP_CONTAINS;
      if (r < 97) return okvt_pkg::OP_GET_POS;
    end else begin
      if (r < 8)  return okvt_pkg::OP_INSERT;
      if (r < 16) return okvt_pkg::OP_UPDATE;
      if (r < 24) return okvt_pkg::OP_UPSERT;
      if (r < 55) return okvt_pkg::OP_ERASE;
      if (r < 68) return okvt_pkg::OP_GET_KEY;
      if (r < 78) return okvt_pkg::OP_CONTAINS;
      if (r < 97) return okvt_pkg::OP_GET_POS;
    end
    return OP_NONE;
  endfunction

  initial begin
    int mode_left;
    bit growing;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(okvt_pkg::OP_GET_POS,  '0, '0, '0);
    send_request(okvt_pkg::OP_ERASE,    '0, '0, '0);
    send_request(okvt_pkg::OP_INSERT,   '0, '0, '0);
    send_request(okvt_pkg::OP_INSERT,   '1, '1, '1);
    send_request(okvt_pkg::OP_INSERT,   '0, 32'h1234_5678, '0);
    send_request(okvt_pkg::OP_UPDATE,   '1, 32'h5a5a_5a5a, '0);
    send_request(okvt_pkg::OP_UPDATE,   32'h1234_5678, 32'h1, '0);
    send_request(okvt_pkg::OP_UPSERT,   '0, 32'ha5a5_a5a5, '0);
    send_request(okvt_pkg::OP_UPSERT,   32'h8000_0001, 32'h8000_0000, '0);
    send_request(okvt_pkg::OP_GET_KEY,  '1, '0, '0);
    send_request(okvt_pkg::OP_GET_KEY,  32'h0000_0001, '0, '0);
    send_request(okvt_pkg::OP_CONTAINS, '0, '0, '0);
    send_request(okvt_pkg::OP_CONTAINS, 32'h7fff_ffff, '0, '0);
    send_request(okvt_pkg::OP_GET_POS,  '0, '0, 4'd0);
    send_request(okvt_pkg::OP_GET_POS,  '0, '0, 4'd2);
    send_request(okvt_pkg::OP_GET_POS,  '0, '0, 4'd3);
    send_request(okvt_pkg::OP_GET_POS,  '0, '0, 4'd15);
    send_request(okvt_pkg::OP_ERASE,    '0, '0, '0);
    send_request(okvt_pkg::OP_GET_POS,  '0, '0, 4'd0);
    send_request(okvt_pkg::OP_GET_POS,  '0, '0, 4'd1);
    send_request(okvt_pkg::OP_ERASE,    32'hdead_beef, '0, '0);
    send_request(OP_NONE,               '1, '1, '1);
    send_request(okvt_pkg::OP_GET_KEY,  32'h8000_0001, '0, '0);

    growing   = 1'b1;
    mode_left = $urandom_range(20, 50);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (mode_left == 0) begin
          growing   = !growing;
          mode_left = $urandom_range(20, 50);
        end
        mode_left--;
        send_request(pick_opcode(growing), pick_key(), $urandom,
                     IDX_W'($urandom_range(15)));
      end
    end

    in_valid_i <= 1'b0;
    while (replies_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
